>>> rtl/core/cswa_pkg.sv
// Shared types, constants and tables for the cosine-sum window block.
// Holds the coefficient table, the cosine quarter-wave builder and the microcode.
// No dependencies.
package cswa_pkg;

	// Quarter-wave cosine table: entries 0..COS_TABLE_DEPTH, Q16 unsigned
	localparam int COS_TABLE_DEPTH = 1024;
	localparam int COS_QB          = $clog2(COS_TABLE_DEPTH);
	localparam int COS_ADDR_W      = COS_QB + 1;
	localparam int COS_IDX_W       = COS_QB + 2;
	localparam logic [31:0] COS_RND = 32'd1 << (31 - COS_IDX_W);
	localparam logic [COS_ADDR_W-1:0] COS_QUARTER = COS_ADDR_W'(COS_TABLE_DEPTH);

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned COS_TAYLOR_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

	localparam int ACC_W  = 36;
	localparam int W_W    = 18;
	localparam int COEF_W = 17;

	typedef logic [COEF_W-1:0] cos_rom_t [COS_TABLE_DEPTH+1];

	typedef enum logic [1:0] {
		REG_WINDOW_TYPE  = 2'd0,
		REG_FRAME_LENGTH = 2'd1,
		REG_PHASE_STEP   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		WIN_RECT     = 3'd0,
		WIN_HANN     = 3'd1,
		WIN_HAMMING  = 3'd2,
		WIN_BLACKMAN = 3'd3,
		WIN_BHARRIS  = 3'd4,
		WIN_FLATTOP  = 3'd5
	} win_type_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_NO_TERMS,
		COND_FEW_TERMS
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_START  = 4'd0;
	localparam step_t ST_FILL1  = 4'd1;
	localparam step_t ST_FILL2  = 4'd2;
	localparam step_t ST_FULL   = 4'd3;
	localparam step_t ST_DRAIN1 = 4'd4;
	localparam step_t ST_DRAIN2 = 4'd5;
	localparam step_t ST_FIN    = 4'd6;
	localparam step_t ST_SCALE  = 4'd7;
	localparam step_t ST_OUT    = 4'd8;

	typedef struct packed {
		logic  init;   // load a0 into the accumulator
		logic  rd;     // cosine table read for the next term
		logic  mul;    // coefficient times cosine
		logic  acc;    // add last product
		logic  fin;    // round and clamp the coefficient
		logic  muls;   // sample times coefficient
		logic  out;    // round, saturate, load output word
		cond_t cond;
		step_t target;
	} cw_t;

	function automatic cw_t ucode(input step_t step);
		cw_t cw;
		cw = '{init: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b0, fin: 1'b0, muls: 1'b0,
			out: 1'b0, cond: COND_NONE, target: ST_START};
		case (step)
			ST_START: begin
				cw.init = 1'b1; cw.rd = 1'b1;
				cw.cond = COND_NO_TERMS; cw.target = ST_FIN;
			end
			ST_FILL1: begin
				cw.rd = 1'b1; cw.mul = 1'b1;
			end
			ST_FILL2: begin
				cw.rd = 1'b1; cw.mul = 1'b1; cw.acc = 1'b1;
				cw.cond = COND_FEW_TERMS; cw.target = ST_DRAIN2;
			end
			ST_FULL: begin
				cw.rd = 1'b1; cw.mul = 1'b1; cw.acc = 1'b1;
			end
			ST_DRAIN1: begin
				cw.mul = 1'b1; cw.acc = 1'b1;
			end
			ST_DRAIN2: cw.acc  = 1'b1;
			ST_FIN:    cw.fin  = 1'b1;
			ST_SCALE:  cw.muls = 1'b1;
			ST_OUT:    cw.out  = 1'b1;
			default:   cw.cond = COND_NONE;
		endcase
		return cw;
	endfunction

	// Q16 magnitude of term k; odd terms are subtracted by the datapath
	function automatic logic [COEF_W-1:0] win_coef(input logic [2:0] wt, input logic [2:0] k);
		logic [COEF_W-1:0] c;
		c = '0;
		case (wt)
			WIN_HANN: begin
				case (k)
					3'd0, 3'd1: c = 17'd32768;
					default:    c = '0;
				endcase
			end
			WIN_HAMMING: begin
				case (k)
					3'd0:    c = 17'd35389;
					3'd1:    c = 17'd30147;
					default: c = '0;
				endcase
			end
			WIN_BLACKMAN: begin
				case (k)
					3'd0:    c = 17'd27525;
					3'd1:    c = 17'd32768;
					3'd2:    c = 17'd5243;
					default: c = '0;
				endcase
			end
			WIN_BHARRIS: begin
				case (k)
					3'd0:    c = 17'd23511;
					3'd1:    c = 17'd32001;
					3'd2:    c = 17'd9259;
					3'd3:    c = 17'd765;
					default: c = '0;
				endcase
			end
			WIN_FLATTOP: begin
				case (k)
					3'd0:    c = 17'd14128;
					3'd1:    c = 17'd27304;
					3'd2:    c = 17'd18171;
					3'd3:    c = 17'd5477;
					3'd4:    c = 17'd455;
					default: c = '0;
				endcase
			end
			default: begin
				// rectangular, and the unused codes
				c = (k == 3'd0) ? 17'd65536 : 17'd0;
			end
		endcase
		return c;
	endfunction

	// Elaboration-time table: Q30 Taylor series to x^14, rounded to Q16
	function automatic cos_rom_t cos_rom_build();
		cos_rom_t rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int r = 0; r <= COS_TABLE_DEPTH; r++) begin
			if (r == COS_TABLE_DEPTH) begin
				rom[r] = '0;
			end else begin
				x = (longint'(r) * PI_HALF_Q30 + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
				x2 = (x * x + (64'd1 << 29)) >> 30;
				term = 64'd1 << 30;
				sum = longint'(term);
				for (int k = 1; k <= 7; k++) begin
					term = ((term * x2) >> 30) / COS_TAYLOR_DIV[k-1];
					if (k % 2 == 1)
						sum = sum - longint'(term);
					else
						sum = sum + longint'(term);
				end
				if (sum < 0)
					sum = 0;
				sum = longint'((longint'(sum) + (64'sd1 <<< 13)) >>> 14);
				if (sum > 65536)
					sum = 65536;
				rom[r] = COEF_W'(sum);
			end
		end
		return rom;
	endfunction

endpackage

>>> rtl/core/cosine_sum_window_apply.sv
// Cosine-sum window: top level with microcode sequencer and shared datapath.
// Depends on cswa_pkg and cswa_cos_rom.
//
// Each accepted sample is weighted by the window coefficient for its place in the
// frame (Hann, Hamming, Blackman, Blackman-Harris, flat-top or rectangular), the
// coefficient being a0 - a1*cos(p) + a2*cos(2p) - a3*cos(3p) + a4*cos(4p) from a
// quarter-wave table. One multiplier does every cosine term and the final scaling
// under a nine-step microprogram: the rectangular window jumps from the start step
// to the coefficient rounding step, Hann, Hamming and Blackman leave out the full
// and first drain steps, and Blackman-Harris and flat-top run all nine. The next
// sample is taken in the cycle its predecessor's word is loaded into the output
// register; a stall on the output holds the sequencer in its last step. Set
// phase_step to 2^32/(frame_length-1); frame_length is clamped to [2, MAX_FRAME].
// Register writes leave position and phase alone.
module cosine_sum_window_apply #(
	parameter int MAX_FRAME    = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] windowed_sample,
	output logic signed [cswa_pkg::W_W-1:0] window_value,
	output logic                           last_in_frame
);

	localparam int POS_W   = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
	localparam int LEN_W   = (POS_W + 1 > 13) ? POS_W + 1 : 13;
	localparam int MUL_A_W = (SAMPLE_WIDTH > cswa_pkg::W_W) ? SAMPLE_WIDTH : cswa_pkg::W_W;
	localparam int PROD_W  = MUL_A_W + cswa_pkg::W_W;
	localparam int ACC_W   = cswa_pkg::ACC_W;
	localparam int W_W     = cswa_pkg::W_W;
	localparam int WF_W    = ACC_W - 16;
	localparam int YF_W    = PROD_W - 16;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
	localparam logic signed [YF_W-1:0] Y_MAX = YF_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [YF_W-1:0] Y_MIN = -Y_MAX - YF_W'(1);
	localparam logic signed [WF_W-1:0] WF_ONE  = WF_W'(65536);
	localparam logic signed [WF_W-1:0] WF_MONE = -WF_ONE;

	// configuration
	logic [2:0]  window_type_q;
	logic [12:0] frame_length_q;
	logic [31:0] phase_step_q;

	// frame position
	logic [POS_W-1:0] pos_q;
	logic [31:0]      phase_q;
	logic [LEN_W-1:0] len;
	logic             last;

	// sequencer
	cswa_pkg::seq_state_t state_q, state_d;
	cswa_pkg::step_t      step_q, step_d;
	cswa_pkg::cw_t        cw;
	logic                 at_out;
	logic                 slot_free;
	logic                 in_acc;
	logic                 cond_hit;

	// datapath
	logic signed [SAMPLE_WIDTH-1:0] smp_q;
	logic [31:0]                    base_q;
	logic [31:0]                    ph_q;
	logic [2:0]                     k_q;
	logic                           last_q;
	logic                           neg_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [W_W-1:0]          w_q;

	logic [31:0]                         ph_rnd;
	logic [cswa_pkg::COS_IDX_W-1:0]      cos_idx;
	logic [1:0]                          quad;
	logic [cswa_pkg::COS_ADDR_W-1:0]     rom_addr;
	logic [cswa_pkg::COEF_W-1:0]         rom_data;
	logic [cswa_pkg::COEF_W-1:0]         coef_k;
	logic [cswa_pkg::COEF_W-1:0]         coef_0;
	logic signed [W_W-1:0]               coef_s;
	logic signed [W_W-1:0]               cos_s;
	logic signed [MUL_A_W-1:0]           mul_a;
	logic signed [W_W-1:0]               mul_b;
	logic signed [PROD_W-1:0]            product;
	logic signed [ACC_W-1:0]             w_sum;
	logic signed [WF_W-1:0]              w_full;
	logic signed [W_W-1:0]               w_sat;
	logic signed [PROD_W-1:0]            y_sum;
	logic signed [YF_W-1:0]              y_full;
	logic signed [SAMPLE_WIDTH-1:0]      y_sat;

	// output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [W_W-1:0]          wv_q;
	logic                           lf_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q  <= cswa_pkg::WIN_RECT;
			frame_length_q <= 13'd1024;
			phase_step_q   <= 32'd4198404;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cswa_pkg::REG_WINDOW_TYPE:  window_type_q  <= cfg_data[2:0];
				cswa_pkg::REG_FRAME_LENGTH: frame_length_q <= cfg_data[12:0];
				cswa_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data;
				default:                    window_type_q  <= window_type_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		cw        = cswa_pkg::ucode(step_q);
		at_out    = (state_q == cswa_pkg::SEQ_RUN) && cw.out;
		slot_free = !out_valid_q || !out_stall;
		in_stall  = !((state_q == cswa_pkg::SEQ_IDLE) || (at_out && slot_free));
		in_acc    = in_valid && !in_stall;

		case (cw.cond)
			cswa_pkg::COND_NO_TERMS:
				cond_hit = !(window_type_q inside {[cswa_pkg::WIN_HANN:cswa_pkg::WIN_FLATTOP]});
			cswa_pkg::COND_FEW_TERMS:
				cond_hit = window_type_q inside {cswa_pkg::WIN_HANN, cswa_pkg::WIN_HAMMING,
					cswa_pkg::WIN_BLACKMAN};
			default:
				cond_hit = 1'b0;
		endcase

		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			cswa_pkg::SEQ_IDLE: begin
				if (in_acc) begin
					state_d = cswa_pkg::SEQ_RUN;
					step_d  = cswa_pkg::ST_START;
				end
			end
			cswa_pkg::SEQ_RUN: begin
				if (cw.out) begin
					if (slot_free) begin
						step_d  = cswa_pkg::ST_START;
						state_d = in_acc ? cswa_pkg::SEQ_RUN : cswa_pkg::SEQ_IDLE;
					end
				end else if (cond_hit) begin
					step_d = cw.target;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			default: state_d = cswa_pkg::SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cswa_pkg::SEQ_IDLE;
			step_q  <= cswa_pkg::ST_START;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// ---------------------------------------------------------------- frame position
	always_comb begin
		len = LEN_W'(frame_length_q);
		if (len < LEN_MIN)
			len = LEN_MIN;
		if (len > LEN_MAX)
			len = LEN_MAX;
		last = LEN_W'(pos_q) >= (len - LEN_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= '0;
		end else if (in_acc) begin
			if (last) begin
				pos_q   <= '0;
				phase_q <= '0;
			end else begin
				pos_q   <= pos_q + POS_W'(1);
				phase_q <= phase_q + phase_step_q;
			end
		end
	end

	// ---------------------------------------------------------------- cosine lookup
	always_comb begin
		ph_rnd  = ph_q + cswa_pkg::COS_RND;
		cos_idx = ph_rnd[31 -: cswa_pkg::COS_IDX_W];
		quad    = cos_idx[cswa_pkg::COS_IDX_W-1 -: 2];
		// odd quadrants read the table mirrored
		if (quad[0])
			rom_addr = cswa_pkg::COS_QUARTER
				- cswa_pkg::COS_ADDR_W'(cos_idx[cswa_pkg::COS_QB-1:0]);
		else
			rom_addr = cswa_pkg::COS_ADDR_W'(cos_idx[cswa_pkg::COS_QB-1:0]);
	end

	cswa_cos_rom u_cos_rom (
		.clk    (clk),
		.rd_en  (cw.rd && (state_q == cswa_pkg::SEQ_RUN)),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	// ---------------------------------------------------------------- shared multiplier
	always_comb begin
		coef_k = cswa_pkg::win_coef(window_type_q, k_q);
		coef_0 = cswa_pkg::win_coef(window_type_q, 3'd0);
		coef_s = k_q[0] ? -$signed({1'b0, coef_k}) : $signed({1'b0, coef_k});
		cos_s  = neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
		if (cw.muls) begin
			mul_a = MUL_A_W'(smp_q);
			mul_b = w_q;
		end else begin
			mul_a = MUL_A_W'(coef_s);
			mul_b = cos_s;
		end
		product = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// coefficient: Q32 to Q16, round half up, clamp
	always_comb begin
		w_sum  = acc_q + ACC_W'(32768);
		w_full = w_sum[ACC_W-1:16];
		if ((window_type_q == cswa_pkg::WIN_BLACKMAN) && w_full[WF_W-1])
			w_sat = '0;
		else if (w_full > WF_ONE)
			w_sat = W_W'(WF_ONE);
		else if (w_full < WF_MONE)
			w_sat = W_W'(WF_MONE);
		else
			w_sat = w_full[W_W-1:0];
	end

	// windowed sample: round half up, saturate
	always_comb begin
		y_sum  = prod_q + PROD_W'(32768);
		y_full = y_sum[PROD_W-1:16];
		if (y_full > Y_MAX)
			y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
		else if (y_full < Y_MIN)
			y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
		else
			y_sat = y_full[SAMPLE_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= sample;
			base_q <= phase_q;
			ph_q   <= phase_q;
			k_q    <= 3'd1;
			last_q <= last;
		end else if (state_q == cswa_pkg::SEQ_RUN) begin
			if (cw.rd) begin
				ph_q  <= ph_q + base_q;
				neg_q <= quad[1] ^ quad[0];
			end
			if (cw.mul) begin
				prod_q <= product;
				k_q    <= k_q + 3'd1;
			end
			if (cw.muls)
				prod_q <= product;
			if (cw.init)
				acc_q <= $signed({{(ACC_W - cswa_pkg::COEF_W - 16){1'b0}}, coef_0, 16'd0});
			else if (cw.acc)
				acc_q <= acc_q + prod_q[ACC_W-1:0];
			if (cw.fin)
				w_q <= w_sat;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (at_out && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (at_out && slot_free) begin
			y_q  <= y_sat;
			wv_q <= w_q;
			lf_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign windowed_sample = y_q;
	assign window_value    = wv_q;
	assign last_in_frame   = lf_q;

endmodule

>>> rtl/core/cswa_cos_rom.sv
// Quarter-wave cosine table with registered read.
// Contents are built at elaboration by cswa_pkg::cos_rom_build.
module cswa_cos_rom (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [cswa_pkg::COS_ADDR_W-1:0]  addr,
	output logic [cswa_pkg::COEF_W-1:0]      data_q
);

	localparam cswa_pkg::cos_rom_t COS_ROM = cswa_pkg::cos_rom_build();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= COS_ROM[addr];
		end
	end

endmodule

>>> rtl/core/cswa_checker.sv
// Port-level checks for cosine_sum_window_apply, attached by bind.
// Depends on nothing but the top level's ports.
module cswa_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] windowed_sample,
	input logic [17:0]             window_value
);

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(windowed_sample)
			&& $stable(window_value))
		else $error("output word changed while stalled");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(window_value) <= 65536) && ($signed(window_value) >= -65536))
		else $error("window coefficient out of range");

	// the sequencer needs several steps per word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in the cycle after an accept");

	a_zero_coef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (window_value == '0) |-> (windowed_sample == '0))
		else $error("zero coefficient gave a non-zero sample");

endmodule

bind cosine_sum_window_apply cswa_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cswa_checker (.*);
